// ===== design/bbpe_pkg.sv =====
// Shared types, constants and helpers for the bicubic Bezier patch evaluator.
// Used by bbpe_ctrl, bbpe_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package bbpe_pkg;

   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;
   localparam int PARAM_W = FRAC_W + 1;
   // derivative values reach 3x a coordinate difference
   localparam int WORK_W  = COORD_W + 4;
   localparam int DIFF_W  = WORK_W + 1;
   localparam int PROD_W  = DIFF_W + PARAM_W + 1;
   localparam int AXES    = 3;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_POS  = 2'd1;
   localparam logic [1:0] OP_DU   = 2'd2;
   localparam logic [1:0] OP_DV   = 2'd3;

   localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << FRAC_W;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [WORK_W-1:0]  work_type;
   typedef logic [PARAM_W-1:0]        param_type;

   typedef struct packed {
      logic       write;      // store control point from request
      logic       capture;    // latch u and v
      logic       row_load;   // fill work regs from one control row
      logic       v_load;     // fill work regs from row results
      logic       diff;       // replace points by 3*(p[i+1]-p[i])
      logic [1:0] row;
      logic       lerp;
      logic [1:0] lerp_idx;
      logic       use_v;
      logic       store_row;
      logic       out_load;
   } cmd_type;

   // level order of de Casteljau pairs: cubic 0,1,2,0,1,0 / quadratic 0,1,0
   function automatic logic [1:0] lerp_index(input logic [2:0] step, input logic quad);
      logic [1:0] idx;
      if (quad) begin
         idx = (step == 3'd1) ? 2'd1 : 2'd0;
      end else begin
         case (step)
            3'd1, 3'd4: idx = 2'd1;
            3'd2:       idx = 2'd2;
            default:    idx = 2'd0;
         endcase
      end
      return idx;
   endfunction

   function automatic work_type triple_diff(input work_type a, input work_type b);
      logic signed [WORK_W+1:0] d;
      d = (WORK_W+2)'(b) - (WORK_W+2)'(a);
      d = d + (d <<< 1);
      return d[WORK_W-1:0];
   endfunction

   function automatic param_type clamp_param(input param_type p);
      return (p > PARAM_ONE) ? PARAM_ONE : p;
   endfunction

endpackage

// ===== design/bbpe_ctrl.sv =====
// Sequencer for the patch evaluator: request/response handshake and the
// row / column de Casteljau schedule. Depends on bbpe_pkg.
`timescale 1ns / 1ps

module bbpe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_op,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output bbpe_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RLOAD = 3'd1;
   localparam logic [2:0] S_RLERP = 3'd2;
   localparam logic [2:0] S_VLOAD = 3'd3;
   localparam logic [2:0] S_VLERP = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] row_ff, row_in;
   logic [2:0] step_ff, step_in;
   logic [1:0] mode_ff, mode_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       quad_u, quad_v, last_step;

   assign quad_u     = (mode_ff == bbpe_pkg::OP_DU);
   assign quad_v     = (mode_ff == bbpe_pkg::OP_DV);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      step_in      = step_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.row      = row_ff;
      last_step    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_op == bbpe_pkg::OP_LOAD) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  mode_in     = req_op;
                  row_in      = 2'd0;
                  state_in    = S_RLOAD;
               end
            end
         end
         S_RLOAD: begin
            cmd.row_load = 1'b1;
            cmd.diff     = quad_u;
            step_in      = 3'd0;
            state_in     = S_RLERP;
         end
         S_RLERP: begin
            last_step     = (step_ff == (quad_u ? 3'd2 : 3'd5));
            cmd.lerp      = 1'b1;
            cmd.lerp_idx  = bbpe_pkg::lerp_index(step_ff, quad_u);
            cmd.store_row = last_step;
            step_in       = step_ff + 3'd1;
            if (last_step) begin
               row_in   = row_ff + 2'd1;
               state_in = (row_ff == 2'd3) ? S_VLOAD : S_RLOAD;
            end
         end
         S_VLOAD: begin
            cmd.v_load = 1'b1;
            cmd.diff   = quad_v;
            step_in    = 3'd0;
            state_in   = S_VLERP;
         end
         S_VLERP: begin
            last_step    = (step_ff == (quad_v ? 3'd2 : 3'd5));
            cmd.lerp     = 1'b1;
            cmd.use_v    = 1'b1;
            cmd.lerp_idx = bbpe_pkg::lerp_index(step_ff, quad_v);
            step_in      = step_ff + 3'd1;
            if (last_step) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= 2'd0;
         step_ff      <= 3'd0;
         mode_ff      <= bbpe_pkg::OP_POS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         step_ff      <= step_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/bbpe_datapath.sv =====
// Control point store, work registers and the shared three-axis lerp unit
// of the patch evaluator, plus the saturating output register. Depends on bbpe_pkg.
`timescale 1ns / 1ps

module bbpe_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  bbpe_pkg::cmd_type    cmd,
   input  logic [3:0]           wr_index,
   input  bbpe_pkg::coord_type  wr_x,
   input  bbpe_pkg::coord_type  wr_y,
   input  bbpe_pkg::coord_type  wr_z,
   input  bbpe_pkg::param_type  param_u,
   input  bbpe_pkg::param_type  param_v,
   output bbpe_pkg::coord_type  out_x,
   output bbpe_pkg::coord_type  out_y,
   output bbpe_pkg::coord_type  out_z,
   output logic                 out_sat
);

   localparam logic signed [bbpe_pkg::PROD_W-1:0] HALF =
      bbpe_pkg::PROD_W'(1) << (bbpe_pkg::FRAC_W - 1);
   localparam bbpe_pkg::work_type COORD_MAX =
      bbpe_pkg::WORK_W'({1'b0, {(bbpe_pkg::COORD_W-1){1'b1}}});
   localparam bbpe_pkg::work_type COORD_MIN = -COORD_MAX - bbpe_pkg::WORK_W'(1);

   // axis, row, column; each column is read at one row address
   bbpe_pkg::coord_type ctrl_ff [bbpe_pkg::AXES][4][4];
   bbpe_pkg::work_type  w_ff    [bbpe_pkg::AXES][4];
   bbpe_pkg::work_type  rows_ff [bbpe_pkg::AXES][4];
   bbpe_pkg::param_type u_ff, v_ff;
   bbpe_pkg::coord_type out_ff [bbpe_pkg::AXES];
   logic                sat_ff;

   bbpe_pkg::coord_type wr_val [bbpe_pkg::AXES];
   bbpe_pkg::work_type  src    [bbpe_pkg::AXES][4];
   bbpe_pkg::work_type  lerp_in[bbpe_pkg::AXES];
   bbpe_pkg::coord_type sat_val[bbpe_pkg::AXES];
   logic [bbpe_pkg::AXES-1:0] clip;

   assign wr_val[0] = wr_x;
   assign wr_val[1] = wr_y;
   assign wr_val[2] = wr_z;

   always_comb begin
      bbpe_pkg::work_type a_v, b_v;
      logic signed [bbpe_pkg::DIFF_W-1:0] d;
      logic signed [bbpe_pkg::PROD_W-1:0] prod;
      logic signed [bbpe_pkg::PROD_W-1:0] t_s;
      logic signed [bbpe_pkg::DIFF_W-1:0] sum;
      t_s = bbpe_pkg::PROD_W'({1'b0, (cmd.use_v ? v_ff : u_ff)});
      for (int a = 0; a < bbpe_pkg::AXES; a++) begin
         for (int c = 0; c < 4; c++) begin
            src[a][c] = cmd.v_load ? rows_ff[a][c]
                                   : bbpe_pkg::WORK_W'(ctrl_ff[a][cmd.row][c]);
         end
         case (cmd.lerp_idx)
            2'd1:    begin a_v = w_ff[a][1]; b_v = w_ff[a][2]; end
            2'd2:    begin a_v = w_ff[a][2]; b_v = w_ff[a][3]; end
            default: begin a_v = w_ff[a][0]; b_v = w_ff[a][1]; end
         endcase
         d    = bbpe_pkg::DIFF_W'(b_v) - bbpe_pkg::DIFF_W'(a_v);
         prod = bbpe_pkg::PROD_W'(d) * t_s + HALF;
         sum  = bbpe_pkg::DIFF_W'(a_v) + bbpe_pkg::DIFF_W'(prod >>> bbpe_pkg::FRAC_W);
         lerp_in[a] = sum[bbpe_pkg::WORK_W-1:0];
         // final clip to the coordinate range
         clip[a]    = (w_ff[a][0] > COORD_MAX) || (w_ff[a][0] < COORD_MIN);
         if (w_ff[a][0] > COORD_MAX) begin
            sat_val[a] = bbpe_pkg::COORD_W'(COORD_MAX);
         end else if (w_ff[a][0] < COORD_MIN) begin
            sat_val[a] = bbpe_pkg::COORD_W'(COORD_MIN);
         end else begin
            sat_val[a] = w_ff[a][0][bbpe_pkg::COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < bbpe_pkg::AXES; a++) begin
            for (int r = 0; r < 4; r++) begin
               for (int c = 0; c < 4; c++) begin
                  ctrl_ff[a][r][c] <= '0;
               end
            end
         end
      end else if (cmd.write) begin
         for (int a = 0; a < bbpe_pkg::AXES; a++) begin
            ctrl_ff[a][wr_index[3:2]][wr_index[1:0]] <= wr_val[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         u_ff <= bbpe_pkg::clamp_param(param_u);
         v_ff <= bbpe_pkg::clamp_param(param_v);
      end
      for (int a = 0; a < bbpe_pkg::AXES; a++) begin
         if (cmd.row_load || cmd.v_load) begin
            for (int c = 0; c < 4; c++) begin
               if (cmd.diff && c < 3) begin
                  w_ff[a][c] <= bbpe_pkg::triple_diff(src[a][c], src[a][c+1]);
               end else begin
                  w_ff[a][c] <= src[a][c];
               end
            end
         end else if (cmd.lerp) begin
            w_ff[a][cmd.lerp_idx] <= lerp_in[a];
         end
         if (cmd.store_row) begin
            rows_ff[a][cmd.row] <= lerp_in[a];
         end
         if (cmd.out_load) begin
            out_ff[a] <= sat_val[a];
         end
      end
      if (cmd.out_load) begin
         sat_ff <= |clip;
      end
   end

   assign out_x   = out_ff[0];
   assign out_y   = out_ff[1];
   assign out_z   = out_ff[2];
   assign out_sat = sat_ff;

endmodule

// ===== design/bicubic_bezier_patch_eval_unit.sv =====
// Bicubic Bezier patch evaluator, top level: sequencer plus datapath.
// Each evaluate runs the row / column de Casteljau schedule with one shared three-axis
// lerp step per cycle and keeps req_tready low until its result is loaded, so a new
// evaluate waits for the last; loads are taken one per cycle while the unit is idle.
// Synchronous active-high reset zeroes all control points and the handshake.
// Depends on bbpe_pkg, bbpe_ctrl, bbpe_datapath.
`timescale 1ns / 1ps

module bicubic_bezier_patch_eval_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // point_index[3:0], coord_x, coord_y, coord_z, param_u, param_v, zero pad
   input  logic [135:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x[31:0], out_y, out_z
   output logic [95:0]  rsp_tdata,
   // saturated[0]
   output logic [0:0]   rsp_tuser
);

   bbpe_pkg::cmd_type   cmd;
   bbpe_pkg::coord_type out_x, out_y, out_z;
   logic                out_sat;

   bbpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   bbpe_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .wr_index (req_tdata[3:0]),
      .wr_x     (req_tdata[35:4]),
      .wr_y     (req_tdata[67:36]),
      .wr_z     (req_tdata[99:68]),
      .param_u  (req_tdata[116:100]),
      .param_v  (req_tdata[133:117]),
      .out_x    (out_x),
      .out_y    (out_y),
      .out_z    (out_z),
      .out_sat  (out_sat)
   );

   assign rsp_tdata = {out_z, out_y, out_x};
   assign rsp_tuser = out_sat;

`ifndef SYNTHESIS
   // an accepted evaluate closes the input
   a_busy_after_eval: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != bbpe_pkg::OP_LOAD) |=> !req_tready)
      else $error("input open during evaluation");
   // a result is only raised by the sequencer, coming out of a busy state with the input closed
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response raised outside done state");
   // loads never produce a response
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && req_tvalid && req_tready && (req_tuser == bbpe_pkg::OP_LOAD)
      |=> !rsp_tvalid)
      else $error("response after load");
`endif

endmodule

// ===== bench/bicubic_bezier_patch_eval_unit_tb.sv =====
// Self-checking bench for the bicubic Bezier patch evaluator: streams control point loads
// and evaluate requests, predicts each result and compares it field by field.
// Depends on bbpe_pkg and bicubic_bezier_patch_eval_unit.
`timescale 1ns / 1ps

module bicubic_bezier_patch_eval_unit_tb;

   typedef struct {
      logic [1:0]          opcode;
      logic [3:0]          idx;
      bbpe_pkg::coord_type x, y, z;
      bbpe_pkg::param_type u, v;
   } patch_req_type;

   typedef struct {
      bbpe_pkg::coord_type x, y, z;
      logic                sat;
   } patch_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   patch_req_type pending_reqs[$];
   patch_rsp_type expected_rsps[$];
   patch_req_type cur_req;
   longint        pts_x[16], pts_y[16], pts_z[16];
   int            errors = 0;
   int            accepted = 0;
   int            hold_cycles = 0;
   bit            hold_done = 0;

   bicubic_bezier_patch_eval_unit dut (.*);

   always #1 clock = ~clock;

   // a + floor(((b-a)*t + half) / one)
   function automatic longint lerp_fx(longint a, longint b, longint t);
      longint d;
      d = b - a;
      return a + ((d * t + (longint'(1) << (bbpe_pkg::FRAC_W - 1))) >>> bbpe_pkg::FRAC_W);
   endfunction

   function automatic longint casteljau(longint p0, longint p1, longint p2, longint p3,
                                        longint t, bit deriv);
      longint w[4];
      int     n;
      if (deriv) begin
         w[0] = 3 * (p1 - p0); w[1] = 3 * (p2 - p1); w[2] = 3 * (p3 - p2);
         n = 3;
      end else begin
         w[0] = p0; w[1] = p1; w[2] = p2; w[3] = p3;
         n = 4;
      end
      for (int k = n - 1; k > 0; k--)
         for (int i = 0; i < k; i++)
            w[i] = lerp_fx(w[i], w[i + 1], t);
      return w[0];
   endfunction

   function automatic bbpe_pkg::coord_type surface_axis(longint cp[16], longint u,
                                                        longint v, logic [1:0] op,
                                                        ref logic clip);
      longint rows[4];
      longint r;
      for (int i = 0; i < 4; i++)
         rows[i] = casteljau(cp[i*4], cp[i*4+1], cp[i*4+2], cp[i*4+3], u,
                             op == bbpe_pkg::OP_DU);
      r = casteljau(rows[0], rows[1], rows[2], rows[3], v, op == bbpe_pkg::OP_DV);
      if (r > 64'sd2147483647) begin
         r = 64'sd2147483647; clip = 1'b1;
      end
      if (r < -64'sd2147483648) begin
         r = -64'sd2147483648; clip = 1'b1;
      end
      return bbpe_pkg::coord_type'(r);
   endfunction

   task automatic queue_req(patch_req_type rq);
      pending_reqs = {pending_reqs, rq};
   endtask

   task automatic predict_patch(patch_req_type rq);
      patch_rsp_type e;
      longint        u, v;
      logic          clip;
      if (rq.opcode == bbpe_pkg::OP_LOAD) begin
         pts_x[rq.idx] = rq.x; pts_y[rq.idx] = rq.y; pts_z[rq.idx] = rq.z;
      end else begin
         u = (rq.u > bbpe_pkg::PARAM_ONE) ? bbpe_pkg::PARAM_ONE : rq.u;
         v = (rq.v > bbpe_pkg::PARAM_ONE) ? bbpe_pkg::PARAM_ONE : rq.v;
         clip = 1'b0;
         e.x = surface_axis(pts_x, u, v, rq.opcode, clip);
         e.y = surface_axis(pts_y, u, v, rq.opcode, clip);
         e.z = surface_axis(pts_z, u, v, rq.opcode, clip);
         e.sat = clip;
         expected_rsps = {expected_rsps, e};
      end
   endtask

   function automatic bbpe_pkg::coord_type rand_coord();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2, 3: return bbpe_pkg::coord_type'($signed($urandom_range(0, 32'h3ffff))
                                            - 32'sh20000);
         default: return bbpe_pkg::coord_type'($urandom);
      endcase
   endfunction

   function automatic bbpe_pkg::param_type rand_param();
      case ($urandom_range(0, 9))
         0: return 17'd0;
         1: return bbpe_pkg::PARAM_ONE;
         2, 3: return bbpe_pkg::param_type'($urandom);
         default: return bbpe_pkg::param_type'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic patch_req_type mk_req(logic [1:0] op, logic [3:0] idx,
                                            bbpe_pkg::coord_type x,
                                            bbpe_pkg::coord_type y,
                                            bbpe_pkg::coord_type z,
                                            bbpe_pkg::param_type u,
                                            bbpe_pkg::param_type v);
      patch_req_type r;
      r.opcode = op; r.idx = idx; r.x = x; r.y = y; r.z = z; r.u = u; r.v = v;
      return r;
   endfunction

   // driver: predicts each transaction as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_patch(cur_req);
            accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 &&
                ((accepted > 300 && accepted < 420) || $urandom_range(0, 99) >= 8)) begin
               cur_req = pending_reqs.pop_front();
               req_tdata <= {2'b0, cur_req.v, cur_req.u, cur_req.z, cur_req.y, cur_req.x,
                             cur_req.idx};
               req_tuser <= cur_req.opcode;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off so the block backs up
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (!hold_done && accepted >= 150) begin
         hold_cycles <= 400;
         hold_done   <= 1'b1;
      end
   end

   always @(posedge clock) begin
      patch_rsp_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result transaction");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_tdata[31:0] !== e.x) begin
                  $error("out_x expected %0d actual %0d", e.x, $signed(rsp_tdata[31:0]));
                  errors++;
               end
               if (rsp_tdata[63:32] !== e.y) begin
                  $error("out_y expected %0d actual %0d", e.y, $signed(rsp_tdata[63:32]));
                  errors++;
               end
               if (rsp_tdata[95:64] !== e.z) begin
                  $error("out_z expected %0d actual %0d", e.z, $signed(rsp_tdata[95:64]));
                  errors++;
               end
               if (rsp_tuser[0] !== e.sat) begin
                  $error("saturated expected %0d actual %0d", e.sat, rsp_tuser[0]);
                  errors++;
               end
            end
         end
         rsp_tready <= (hold_cycles == 0) &&
                       ((accepted > 300 && accepted < 420) || $urandom_range(0, 99) >= 8);
      end
   end

   initial begin
      int n;
      // directed: evaluate the all-zero patch, then extremes and alternating signs
      queue_req(mk_req(bbpe_pkg::OP_POS, 4'd0, 0, 0, 0, 17'd0, 17'd0));
      for (int i = 0; i < 16; i++)
         queue_req(mk_req(bbpe_pkg::OP_LOAD, i[3:0],
            (i % 2) ? 32'sh7fffffff : 32'sh80000000,
            ((i / 4) % 2) ? 32'sh7fffffff : 32'sh80000000,
            32'sh7fffffff, 17'h1ffff, 17'h1ffff));
      queue_req(mk_req(bbpe_pkg::OP_POS, 4'hf, 32'sh7fffffff, 32'sh80000000, -1,
                       17'd32768, 17'd32768));
      queue_req(mk_req(bbpe_pkg::OP_DU, 4'd0, 0, 0, 0, 17'd0, 17'd65536));
      queue_req(mk_req(bbpe_pkg::OP_DV, 4'd0, 0, 0, 0, 17'd65536, 17'd0));
      // parameters above one clamp to one
      queue_req(mk_req(bbpe_pkg::OP_DU, 4'd0, 0, 0, 0, 17'h1ffff, 17'd65537));
      queue_req(mk_req(bbpe_pkg::OP_DV, 4'd0, 0, 0, 0, 17'd65535, 17'h1ffff));
      queue_req(mk_req(bbpe_pkg::OP_POS, 4'd0, 0, 0, 0, 17'd65536, 17'd65536));

      n = pending_reqs.size();
      while (n < 720) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_req(mk_req(2'($urandom), 4'($urandom), bbpe_pkg::coord_type'($urandom),
               bbpe_pkg::coord_type'($urandom), bbpe_pkg::coord_type'($urandom),
               bbpe_pkg::param_type'($urandom), bbpe_pkg::param_type'($urandom)));
            n++;
         end else begin
            repeat ($urandom_range(0, 16)) begin
               queue_req(mk_req(bbpe_pkg::OP_LOAD, 4'($urandom), rand_coord(),
                  rand_coord(), rand_coord(), bbpe_pkg::param_type'($urandom),
                  bbpe_pkg::param_type'($urandom)));
               n++;
            end
            repeat ($urandom_range(1, 4)) begin
               queue_req(mk_req(2'($urandom_range(1, 3)), 4'($urandom),
                  bbpe_pkg::coord_type'($urandom), bbpe_pkg::coord_type'($urandom),
                  bbpe_pkg::coord_type'($urandom), rand_param(), rand_param()));
               n++;
            end
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("results still outstanding: %0d", expected_rsps.size());
         errors++;
      end
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #800000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== bicubic_bezier_patch_eval_unit.f =====
design/bbpe_pkg.sv
design/bbpe_ctrl.sv
design/bbpe_datapath.sv
design/bicubic_bezier_patch_eval_unit.sv
bench/bicubic_bezier_patch_eval_unit_tb.sv
